// ----- rtl/bfs_pkg.sv -----
// Package for the byte frequency sort block: sizes, counter type, controller states
// and the command/status structs between controller and datapath. No dependencies.
package bfs_pkg;

  localparam int unsigned SYMBOL_COUNT = 256;
  localparam int unsigned COUNT_BITS   = 16;
  localparam int unsigned IDX_W        = $clog2(SYMBOL_COUNT);
  localparam int unsigned SYM_BITS     = 8;
  localparam int unsigned LEN_BITS     = 16;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_W-1:0]      idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_SCAN,
    ST_SCAN_END,
    ST_FCLR,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic cnt_write;
    logic fetch_clear;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/byte_frequency_sort.sv -----
// Byte frequency sort: histogram of byte symbols read back as runs, largest count first.
// Count transaction: states CNT_RD, CNT_WR and RESULT; the result is loaded once the output is free.
// Fetch transaction: the scan of the counter memory visits one entry per cycle, then SCAN_END, FCLR
// and RESULT follow; in both, the next input is taken only in IDLE, after the result is loaded.
// Reset: asynchronous, active low; clears all counter valid bits, so the histogram
// reads as empty at once with no clearing pass. Depends on bfs_pkg, bfs_ctrl, bfs_datapath.
module byte_frequency_sort (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [bfs_pkg::SYM_BITS-1:0]  symbol_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [bfs_pkg::SYM_BITS-1:0]  run_symbol_o,
  output logic [bfs_pkg::LEN_BITS-1:0]  run_length_o
);

  bfs_pkg::cmd_t cmd;
  bfs_pkg::sts_t sts;

  bfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bfs_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .action_i     (action_i),
    .symbol_i     (symbol_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .found_o      (found_o),
    .run_symbol_o (run_symbol_o),
    .run_length_o (run_length_o)
  );

endmodule

// ----- rtl/bfs_datapath.sv -----
// Datapath of the byte frequency sort block: counter memory with valid bits,
// scan index, running maximum and output register. Depends on bfs_pkg.
module bfs_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfs_pkg::cmd_t                 cmd_i,
  output bfs_pkg::sts_t                 sts_o,
  input  logic                          action_i,
  input  logic [bfs_pkg::SYM_BITS-1:0]  symbol_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic                          found_o,
  output logic [bfs_pkg::SYM_BITS-1:0]  run_symbol_o,
  output logic [bfs_pkg::LEN_BITS-1:0]  run_length_o
);

  localparam bfs_pkg::count_t CntMax = '1;

  bfs_pkg::count_t                  mem_q [bfs_pkg::SYMBOL_COUNT];
  logic [bfs_pkg::SYMBOL_COUNT-1:0] vld_q;

  logic                         in_act_q;
  logic [bfs_pkg::SYM_BITS-1:0] in_sym_q;
  bfs_pkg::idx_t                scan_idx_q;
  bfs_pkg::idx_t                rd_idx_q;
  bfs_pkg::idx_t                rd_addr;
  bfs_pkg::count_t              rd_data_q;
  logic                         rd_vld_q;
  logic                         rd_pend_q;
  bfs_pkg::count_t              best_q;
  bfs_pkg::idx_t                best_sym_q;

  logic                          out_valid_q;
  logic                          found_q;
  logic [bfs_pkg::SYM_BITS-1:0]  run_sym_q;
  logic [bfs_pkg::LEN_BITS-1:0]  run_len_q;

  bfs_pkg::count_t              cur;
  bfs_pkg::count_t              inc;
  logic                         in_range;
  logic                         best_nz;
  logic [31:0]                  best_ext;
  logic [bfs_pkg::LEN_BITS-1:0] best_len;

  assign rd_addr  = cmd_i.scan_step ? scan_idx_q : in_sym_q[bfs_pkg::IDX_W-1:0];
  assign cur      = rd_vld_q ? rd_data_q : '0;
  assign inc      = (cur == CntMax) ? cur : cur + bfs_pkg::COUNT_BITS'(1);
  assign in_range = {1'b0, in_sym_q} < 9'(bfs_pkg::SYMBOL_COUNT);
  assign best_nz  = best_q != '0;
  assign best_ext = 32'(best_q);
  assign best_len = (best_ext > 32'd65535) ? '1 : best_ext[bfs_pkg::LEN_BITS-1:0];

  assign sts_o.scan_last = scan_idx_q == bfs_pkg::IDX_W'(bfs_pkg::SYMBOL_COUNT - 1);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr];
    if (cmd_i.cnt_write && in_range) begin
      mem_q[in_sym_q[bfs_pkg::IDX_W-1:0]] <= inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_pend_q   <= 1'b0;
      scan_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q  <= vld_q[rd_addr];
      rd_pend_q <= cmd_i.scan_step;
      if (cmd_i.capture) begin
        scan_idx_q <= '0;
      end else if (cmd_i.scan_step && !sts_o.scan_last) begin
        scan_idx_q <= scan_idx_q + bfs_pkg::IDX_W'(1);
      end
      if (cmd_i.cnt_write && in_range) begin
        vld_q[in_sym_q[bfs_pkg::IDX_W-1:0]] <= 1'b1;
      end else if (cmd_i.fetch_clear && best_nz) begin
        vld_q[best_sym_q] <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_idx_q;
    if (cmd_i.capture) begin
      in_act_q   <= action_i;
      in_sym_q   <= symbol_i;
      best_q     <= '0;
      best_sym_q <= '0;
    end else if (rd_pend_q && (cur > best_q)) begin
      best_q     <= cur;
      best_sym_q <= rd_idx_q;
    end
    if (cmd_i.out_load) begin
      found_q   <= in_act_q && best_nz;
      run_sym_q <= (in_act_q && best_nz) ? bfs_pkg::SYM_BITS'(best_sym_q) : '0;
      run_len_q <= (in_act_q && best_nz) ? best_len : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign run_symbol_o = run_sym_q;
  assign run_length_o = run_len_q;

endmodule

// ----- rtl/bfs_ctrl.sv -----
// Controller of the byte frequency sort block: sequences count and fetch
// transactions and commands the datapath. Depends on bfs_pkg.
module bfs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          action_i,
  output logic          in_stall_o,
  input  bfs_pkg::sts_t sts_i,
  output bfs_pkg::cmd_t cmd_o
);

  bfs_pkg::state_e state_q;
  bfs_pkg::state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      bfs_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = action_i ? bfs_pkg::ST_SCAN : bfs_pkg::ST_CNT_RD;
        end
      end
      bfs_pkg::ST_CNT_RD: begin
        state_d = bfs_pkg::ST_CNT_WR;
      end
      bfs_pkg::ST_CNT_WR: begin
        cmd_o.cnt_write = 1'b1;
        state_d         = bfs_pkg::ST_RESULT;
      end
      bfs_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = bfs_pkg::ST_SCAN_END;
        end
      end
      bfs_pkg::ST_SCAN_END: begin
        state_d = bfs_pkg::ST_FCLR;
      end
      bfs_pkg::ST_FCLR: begin
        cmd_o.fetch_clear = 1'b1;
        state_d           = bfs_pkg::ST_RESULT;
      end
      bfs_pkg::ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = bfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bfs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- tb/tb_byte_frequency_sort.sv -----
// Self-checking testbench for byte_frequency_sort: a directed table, a burst pass with no
// idling and random count/fetch traffic, each checked against an in-bench histogram predictor.
// Depends on bfs_pkg and the byte_frequency_sort RTL.
`timescale 1ns / 1ps

module tb_byte_frequency_sort;

  localparam int unsigned RANDOM_ITEMS = 1680;
  localparam int unsigned BURST_COUNTS = 200;
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned IDLE_PCT     = 23;
  localparam int unsigned CYCLE_LIMIT  = 5000000;
  localparam int unsigned PRINT_LIMIT  = 50;
  localparam int unsigned N_DIRECTED   = 18;

  typedef enum logic {
    ACT_COUNT = 1'b0,
    ACT_FETCH = 1'b1
  } action_e;

  typedef struct packed {
    logic                         found;
    logic [bfs_pkg::SYM_BITS-1:0] sym;
    logic [bfs_pkg::LEN_BITS-1:0] len;
  } run_t;

  typedef struct packed {
    action_e                      act;
    logic [bfs_pkg::SYM_BITS-1:0] sym;
    logic                         typed;
    run_t                         run;
  } stim_row_t;

  localparam run_t NO_RUN = '0;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         action_i;
  logic [bfs_pkg::SYM_BITS-1:0] symbol_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic                         found_o;
  logic [bfs_pkg::SYM_BITS-1:0] run_symbol_o;
  logic [bfs_pkg::LEN_BITS-1:0] run_length_o;

  bfs_pkg::count_t symbol_tally [bfs_pkg::SYMBOL_COUNT];
  run_t            runs_due [$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned items_sent;
  int unsigned fetches_sent;
  int unsigned results_seen;
  int unsigned runs_found;
  int unsigned longest_run;
  bit          idle_on;
  bit          hold_req;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ACT_FETCH, 8'h00, 1'b1, NO_RUN},
    '{ACT_COUNT, 8'h00, 1'b1, NO_RUN},
    '{ACT_COUNT, 8'hFF, 1'b1, NO_RUN},
    '{ACT_COUNT, 8'hFF, 1'b1, NO_RUN},
    '{ACT_COUNT, 8'hAA, 1'b1, NO_RUN},
    '{ACT_COUNT, 8'h55, 1'b1, NO_RUN},
    '{ACT_COUNT, 8'h55, 1'b1, NO_RUN},
    '{ACT_FETCH, 8'hFF, 1'b0, NO_RUN},
    '{ACT_FETCH, 8'h00, 1'b0, NO_RUN},
    '{ACT_FETCH, 8'h5A, 1'b0, NO_RUN},
    '{ACT_FETCH, 8'hA5, 1'b0, NO_RUN},
    '{ACT_FETCH, 8'hFF, 1'b1, NO_RUN},
    '{ACT_COUNT, 8'h80, 1'b1, NO_RUN},
    '{ACT_COUNT, 8'h7F, 1'b1, NO_RUN},
    '{ACT_COUNT, 8'h80, 1'b1, NO_RUN},
    '{ACT_FETCH, 8'h00, 1'b0, NO_RUN},
    '{ACT_FETCH, 8'h00, 1'b0, NO_RUN},
    '{ACT_FETCH, 8'h01, 1'b1, NO_RUN}
  };

  byte_frequency_sort dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .symbol_i     (symbol_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .found_o      (found_o),
    .run_symbol_o (run_symbol_o),
    .run_length_o (run_length_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic run_t next_run(input action_e act,
                                    input logic [bfs_pkg::SYM_BITS-1:0] sym);
    run_t            r;
    bfs_pkg::count_t top;
    int              top_sym;
    r       = '0;
    top     = '0;
    top_sym = 0;
    if (act == ACT_COUNT) begin
      if (int'(sym) < bfs_pkg::SYMBOL_COUNT && symbol_tally[sym] != '1) begin
        symbol_tally[sym] = symbol_tally[sym] + 1'b1;
      end
      return r;
    end
    for (int i = 0; i < bfs_pkg::SYMBOL_COUNT; i++) begin
      if (symbol_tally[i] > top) begin
        top     = symbol_tally[i];
        top_sym = i;
      end
    end
    if (top != '0) begin
      symbol_tally[top_sym] = '0;
      r.found = 1'b1;
      r.sym   = bfs_pkg::SYM_BITS'(top_sym);
      r.len   = (32'(top) > 32'hFFFF) ? '1 : bfs_pkg::LEN_BITS'(top);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= PRINT_LIMIT) begin
      $display("mismatch: %s at result %0d, got %0h want %0h", what, results_seen, got, want);
    end
  endtask

  task automatic send_item(input action_e act, input logic [bfs_pkg::SYM_BITS-1:0] sym,
                           input bit typed, input run_t typed_run);
    run_t due;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    symbol_i   <= sym;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    due = next_run(act, sym);
    runs_due.push_back(typed ? typed_run : due);
    items_sent++;
    if (act == ACT_FETCH) fetches_sent++;
  endtask

  // fetch every live run, then one more to see not-found
  task automatic drain_histogram();
    int live;
    live = 0;
    foreach (symbol_tally[i]) begin
      if (symbol_tally[i] != '0) live++;
    end
    repeat (live + 1) begin
      send_item(ACT_FETCH, bfs_pkg::SYM_BITS'($urandom_range(0, 255)), 1'b0, NO_RUN);
    end
  endtask

  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    run_t got;
    run_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {found_o, run_symbol_o, run_length_o};
      results_seen++;
      if (got.found) begin
        runs_found++;
        if (32'(got.len) > longest_run) longest_run = 32'(got.len);
      end
      if (runs_due.size() == 0) begin
        report_mismatch("result with nothing pending", int'(got), 0);
      end else begin
        want = runs_due.pop_front();
        if (got.found !== want.found) begin
          report_mismatch("found", int'(got.found), int'(want.found));
        end
        if (got.sym !== want.sym) begin
          report_mismatch("run_symbol", int'(got.sym), int'(want.sym));
        end
        if (got.len !== want.len) begin
          report_mismatch("run_length", int'(got.len), int'(want.len));
        end
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles with %0d results pending", cycles, runs_due.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned rand_start;
    int unsigned pick;
    int unsigned alpha_n;
    int unsigned base;
    int unsigned stride;
    bit          hold_done;
    errors     = 0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    idle_on    = 1'b1;
    in_valid_i = 1'b0;
    action_i   = ACT_COUNT;
    symbol_i   = '0;
    rst_ni     = 1'b0;
    foreach (symbol_tally[i]) symbol_tally[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].act, directed_rows[i].sym,
                directed_rows[i].typed, directed_rows[i].run);
    end

    // back-to-back counts on one symbol with no idling on either side
    idle_on = 1'b0;
    repeat (BURST_COUNTS) send_item(ACT_COUNT, 8'hC3, 1'b0, NO_RUN);
    send_item(ACT_COUNT, 8'h01, 1'b0, NO_RUN);
    drain_histogram();
    idle_on = 1'b1;

    rand_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      if (!hold_done && items_sent - rand_start >= RANDOM_ITEMS / 2) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        alpha_n = $urandom_range(1, 6);
        base    = $urandom_range(0, 255);
        stride  = $urandom_range(1, 40);
        repeat ($urandom_range(1, 30)) begin
          send_item(ACT_COUNT,
                    bfs_pkg::SYM_BITS'(base + stride * $urandom_range(0, alpha_n - 1)),
                    1'b0, NO_RUN);
        end
        if ($urandom_range(0, 3) != 0) drain_histogram();
      end else if (pick < 9) begin
        send_item(($urandom_range(0, 3) == 0) ? ACT_FETCH : ACT_COUNT,
                  bfs_pkg::SYM_BITS'($urandom_range(0, 255)), 1'b0, NO_RUN);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_item(ACT_FETCH, bfs_pkg::SYM_BITS'($urandom_range(0, 255)), 1'b0, NO_RUN);
        end
      end
    end
    in_valid_i <= 1'b0;

    while (runs_due.size() != 0) @(posedge clk_i);
    repeat (bfs_pkg::SYMBOL_COUNT + 8) @(posedge clk_i);

    $display("ran %0d transactions (%0d fetches) in %0d cycles, including a no-idle burst",
             items_sent, fetches_sent, cycles);
    $display("checked %0d results, %0d runs returned, longest run %0d, %0d mismatches",
             results_seen, runs_found, longest_run, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
